FILE: rtl/core/tmse_pkg.sv
// Shared types, codes and default sizes for the Turing machine step engine.
package tmse_pkg;

   // Fixed field widths of the command and result beats
   localparam int KIND_W    = 3;
   localparam int RIDX_W    = 6;
   localparam int MSTATE_W  = 4;
   localparam int SYM_W     = 8;
   localparam int MOVE_W    = 2;
   localparam int ADDR_W    = 10;
   localparam int STATUS_W  = 2;

   // Default storage sizes
   localparam int RULE_ENTRIES_DEF = 64;
   localparam int TAPE_CELLS_DEF   = 1024;

   // Command kinds
   localparam logic [KIND_W-1:0] KIND_LOAD  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_WRITE = 3'd1;
   localparam logic [KIND_W-1:0] KIND_START = 3'd2;
   localparam logic [KIND_W-1:0] KIND_STEP  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_READ  = 3'd4;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_HALTED_NOW = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_IGNORED    = 2'd2;

   // Head move codes; the unused code acts as stay
   localparam logic [MOVE_W-1:0] MOVE_STAY = 2'd0;
   localparam logic [MOVE_W-1:0] MOVE_INC  = 2'd1;
   localparam logic [MOVE_W-1:0] MOVE_DEC  = 2'd2;

   // Machine state after start
   localparam logic [MSTATE_W-1:0] STATE_INIT = 4'd0;

   typedef struct packed {
      logic                valid;
      logic [MSTATE_W-1:0] state;
      logic [SYM_W-1:0]    symbol;
      logic [SYM_W-1:0]    wr;
      logic [MOVE_W-1:0]   move;
      logic [MSTATE_W-1:0] nxt;
   } rule_entry_type;

endpackage

FILE: rtl/core/turing_machine_step_engine.sv
// Top level of the Turing machine step engine: sequencer, rule table and tape store.
// Quick beats (load rule, write tape, start, unknown kinds, step while halted): result the
//   cycle after accept, busy stays low, one beat per cycle; read tape: through S_READ, then the
//   result register. Step: tape fetch, scan of rules from entry zero in S_SCAN, S_FIRE for the
//   first match, or a halt result when none matches; busy drops with the result strobe, which
//   the receiver cannot stall. Synchronous reset clears both stores entry by entry, busy high.
module turing_machine_step_engine #(
   parameter int RULE_ENTRIES = tmse_pkg::RULE_ENTRIES_DEF,
   parameter int TAPE_CELLS   = tmse_pkg::TAPE_CELLS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [tmse_pkg::KIND_W-1:0]    req_kind,
   input  logic [tmse_pkg::RIDX_W-1:0]    req_rule_index,
   input  logic                           req_rule_valid,
   input  logic [tmse_pkg::MSTATE_W-1:0]  req_rule_state,
   input  logic [tmse_pkg::SYM_W-1:0]     req_rule_symbol,
   input  logic [tmse_pkg::SYM_W-1:0]     req_rule_write,
   input  logic [tmse_pkg::MOVE_W-1:0]    req_rule_move,
   input  logic [tmse_pkg::MSTATE_W-1:0]  req_rule_next,
   input  logic [tmse_pkg::ADDR_W-1:0]    req_tape_address,
   input  logic [tmse_pkg::SYM_W-1:0]     req_tape_symbol,
   output logic                           rsp_valid,
   output logic [tmse_pkg::STATUS_W-1:0]  rsp_status,
   output logic                           rsp_halted,
   output logic [tmse_pkg::MSTATE_W-1:0]  rsp_state_now,
   output logic [tmse_pkg::ADDR_W-1:0]    rsp_head_now,
   output logic [tmse_pkg::SYM_W-1:0]     rsp_symbol_out
);

   localparam int RIW       = $clog2(RULE_ENTRIES);
   localparam int TAW       = $clog2(TAPE_CELLS);
   localparam int CLEAR_LEN = (TAPE_CELLS > RULE_ENTRIES) ? TAPE_CELLS : RULE_ENTRIES;
   localparam int CW        = $clog2(CLEAR_LEN);

   localparam logic [TAW-1:0] HEAD_MAX  = TAW'(TAPE_CELLS - 1);
   localparam logic [RIW-1:0] RIDX_LAST = RIW'(RULE_ENTRIES - 1);
   localparam logic [CW-1:0]  CLR_LAST  = CW'(CLEAR_LEN - 1);

   // Sequencer codes
   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_FIRE  = 3'd4;

   // Storage
   tmse_pkg::rule_entry_type  rule_mem [RULE_ENTRIES];
   logic [tmse_pkg::SYM_W-1:0] tape_mem [TAPE_CELLS];

   // Control and machine registers
   logic [2:0]                      state_ff, state_in;
   logic [CW-1:0]                   clr_ff, clr_in;
   logic [TAW-1:0]                  head_ff, head_in;
   logic [tmse_pkg::MSTATE_W-1:0]   mstate_ff, mstate_in;
   logic                            halted_ff, halted_in;
   logic [RIW-1:0]                  scan_ff, scan_in;
   logic                            pend_ff, pend_in;
   logic                            pend_last_ff, pend_last_in;
   logic                            rd_ok_ff, rd_ok_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [tmse_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [tmse_pkg::SYM_W-1:0]      rsp_symbol_ff, rsp_symbol_in;

   // Memory read data
   tmse_pkg::rule_entry_type        rule_q_ff;
   logic [tmse_pkg::SYM_W-1:0]      tape_q_ff;

   // Memory port controls
   logic                            tape_we, tape_re;
   logic [TAW-1:0]                  tape_waddr, tape_raddr;
   logic [tmse_pkg::SYM_W-1:0]      tape_wdata;
   logic                            rule_we, rule_re;
   logic [RIW-1:0]                  rule_waddr;
   tmse_pkg::rule_entry_type        rule_wdata;

   // Decoded command beat
   logic                            accept;
   logic                            addr_ok, ridx_ok;
   logic [31:0]                     addr_ext, ridx_ext, clr_ext;
   logic [31:0]                     head_ext;
   logic [TAW-1:0]                  addr_idx;
   logic                            hit;

   assign busy     = (state_ff != S_IDLE);
   assign accept   = start && !busy;

   assign addr_ext = 32'(req_tape_address);
   assign ridx_ext = 32'(req_rule_index);
   assign clr_ext  = 32'(clr_ff);
   assign head_ext = 32'(head_ff);
   assign addr_ok  = (addr_ext < 32'(TAPE_CELLS));
   assign ridx_ok  = (ridx_ext < 32'(RULE_ENTRIES));
   assign addr_idx = addr_ext[TAW-1:0];

   // The one compare unit: entry fetched last cycle against state and symbol under head
   assign hit = pend_ff && rule_q_ff.valid && (rule_q_ff.state == mstate_ff) &&
                (rule_q_ff.symbol == tape_q_ff);

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      head_in       = head_ff;
      mstate_in     = mstate_ff;
      halted_in     = halted_ff;
      scan_in       = scan_ff;
      pend_in       = pend_ff;
      pend_last_in  = pend_last_ff;
      rd_ok_in      = rd_ok_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = tmse_pkg::STATUS_DONE;
      rsp_symbol_in = '0;

      tape_we    = 1'b0;
      tape_waddr = addr_idx;
      tape_wdata = req_tape_symbol;
      tape_re    = 1'b0;
      tape_raddr = addr_idx;
      rule_we    = 1'b0;
      rule_waddr = ridx_ext[RIW-1:0];
      rule_wdata = '{valid:  req_rule_valid,
                     state:  req_rule_state,
                     symbol: req_rule_symbol,
                     wr:     req_rule_write,
                     move:   req_rule_move,
                     nxt:    req_rule_next};
      rule_re    = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            // Sweep both stores to their reset contents, one entry a cycle
            tape_we    = (clr_ext < 32'(TAPE_CELLS));
            tape_waddr = clr_ff[TAW-1:0];
            tape_wdata = '0;
            rule_we    = (clr_ext < 32'(RULE_ENTRIES));
            rule_waddr = clr_ff[RIW-1:0];
            rule_wdata = '0;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == CLR_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               unique case (req_kind)
                  tmse_pkg::KIND_LOAD: begin
                     rule_we      = ridx_ok;
                     rsp_valid_in = 1'b1;
                  end
                  tmse_pkg::KIND_WRITE: begin
                     tape_we      = addr_ok;
                     rsp_valid_in = 1'b1;
                  end
                  tmse_pkg::KIND_START: begin
                     mstate_in    = tmse_pkg::STATE_INIT;
                     halted_in    = 1'b0;
                     head_in      = addr_ok ? addr_idx : HEAD_MAX;
                     rsp_valid_in = 1'b1;
                  end
                  tmse_pkg::KIND_STEP: begin
                     if (halted_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = tmse_pkg::STATUS_IGNORED;
                     end else begin
                        // Fetch the symbol under the head, then scan from entry zero
                        tape_re    = 1'b1;
                        tape_raddr = head_ff;
                        scan_in    = '0;
                        pend_in    = 1'b0;
                        state_in   = S_SCAN;
                     end
                  end
                  tmse_pkg::KIND_READ: begin
                     tape_re  = 1'b1;
                     rd_ok_in = addr_ok;
                     state_in = S_READ;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            rsp_valid_in  = 1'b1;
            rsp_symbol_in = rd_ok_ff ? tape_q_ff : '0;
            state_in      = S_IDLE;
         end
         S_SCAN: begin
            priority if (hit) begin
               // Hold the matching entry in the read register and fire
               state_in = S_FIRE;
            end else if (pend_ff && pend_last_ff) begin
               halted_in     = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_status_in = tmse_pkg::STATUS_HALTED_NOW;
               state_in      = S_IDLE;
            end else begin
               rule_re      = 1'b1;
               pend_in      = 1'b1;
               pend_last_in = (scan_ff == RIDX_LAST);
               scan_in      = scan_ff + 1'b1;
            end
         end
         S_FIRE: begin
            tape_we    = 1'b1;
            tape_waddr = head_ff;
            tape_wdata = rule_q_ff.wr;
            unique case (rule_q_ff.move)
               tmse_pkg::MOVE_INC: begin
                  if (head_ff != HEAD_MAX) begin
                     head_in = head_ff + 1'b1;
                  end
               end
               tmse_pkg::MOVE_DEC: begin
                  if (head_ff != '0) begin
                     head_in = head_ff - 1'b1;
                  end
               end
               default: begin
                  head_in = head_ff;
               end
            endcase
            mstate_in     = rule_q_ff.nxt;
            rsp_valid_in  = 1'b1;
            rsp_symbol_in = rule_q_ff.wr;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control and machine registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         head_ff      <= '0;
         mstate_ff    <= tmse_pkg::STATE_INIT;
         halted_ff    <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         head_ff      <= head_in;
         mstate_ff    <= mstate_in;
         halted_ff    <= halted_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      pend_last_ff  <= pend_last_in;
      rd_ok_ff      <= rd_ok_in;
      rsp_status_ff <= rsp_status_in;
      rsp_symbol_ff <= rsp_symbol_in;
   end

   // Tape store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (tape_we) begin
         tape_mem[tape_waddr] <= tape_wdata;
      end
      if (tape_re) begin
         tape_q_ff <= tape_mem[tape_raddr];
      end
   end

   // Rule table: one write port, registered read at the scan pointer
   always_ff @(posedge clock) begin
      if (rule_we) begin
         rule_mem[rule_waddr] <= rule_wdata;
      end
      if (rule_re) begin
         rule_q_ff <= rule_mem[scan_ff];
      end
   end

   // Machine state is updated on the same edge as the strobe, so show it live
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_halted     = halted_ff;
   assign rsp_state_now  = mstate_ff;
   assign rsp_head_now   = head_ext[tmse_pkg::ADDR_W-1:0];
   assign rsp_symbol_out = rsp_symbol_ff;

endmodule

FILE: rtl/core/tmse_checker.sv
// Port-level assertions for the Turing machine step engine, bound to the top level.
module tmse_port_checks (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic [tmse_pkg::KIND_W-1:0]    req_kind,
   input logic                           rsp_valid,
   input logic [tmse_pkg::STATUS_W-1:0]  rsp_status,
   input logic                           rsp_halted,
   input logic [tmse_pkg::MSTATE_W-1:0]  rsp_state_now,
   input logic [tmse_pkg::SYM_W-1:0]     rsp_symbol_out
);

   logic accept;
   logic quick_kind;

   assign accept     = start && !busy;
   assign quick_kind = (req_kind == tmse_pkg::KIND_LOAD) ||
                       (req_kind == tmse_pkg::KIND_WRITE) ||
                       (req_kind == tmse_pkg::KIND_START) ||
                       (req_kind > tmse_pkg::KIND_READ);

   // Every accepted beat either keeps the engine busy or answers at once
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy || rsp_valid))
      else $error("accepted beat neither busy nor answered");

   // Load, write, start and unknown commands answer on the next cycle
   a_quick_answer: assert property (@(posedge clock) disable iff (reset)
      (accept && quick_kind) |=> (rsp_valid && !busy))
      else $error("single-cycle command not answered next cycle");

   // Start leaves the machine running in the init state
   a_start_result: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_kind == tmse_pkg::KIND_START)) |=>
         (rsp_status == tmse_pkg::STATUS_DONE && !rsp_halted &&
          rsp_state_now == tmse_pkg::STATE_INIT))
      else $error("start result wrong");

   // A halt or an ignored step reports halted and writes no symbol
   a_halt_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == tmse_pkg::STATUS_HALTED_NOW ||
                     rsp_status == tmse_pkg::STATUS_IGNORED)) |->
         (rsp_halted && rsp_symbol_out == '0))
      else $error("halt result inconsistent");

endmodule

bind turing_machine_step_engine tmse_port_checks u_tmse_port_checks (.*);
